/* sv/fbnd_pkg.sv */
// fbnd_pkg: shared widths, constants, codes and command/status types
// for the fit-box nearest downscaler; no dependencies
`timescale 1ns / 1ps

package fbnd_pkg;

    localparam int DIM_W       = 15;
    localparam int PIX_W       = 32;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int CNT_W       = $clog2(PROD_W);
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_DIM     = 16384;
    localparam int PIXEL_LIMIT = 64 * 1024 * 1024;
    localparam logic [PIX_W-1:0] OPAQUE = 32'hff00_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_BOX_WIDTH  = 2'd2,
        CFG_BOX_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_PROD_WH   = 4'd1,
        OP_CHECK     = 4'd2,
        OP_PROD_BHW  = 4'd3,
        OP_PICK      = 4'd4,
        OP_SIZE_GO   = 4'd5,
        OP_SIZE_DONE = 4'd6,
        OP_COL_GO    = 4'd7,
        OP_COL_DONE  = 4'd8,
        OP_ROW_GO    = 4'd9,
        OP_ROW_DONE  = 4'd10
    } op_t;

    typedef struct packed {
        logic hold;
        logic step_in;
        logic step_held;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic invalid;
        logic full_fit;
        logic div_done;
    } stat_t;

endpackage

/* sv/fbnd_div.sv */
// fbnd_div: restoring divider, one quotient bit per cycle
// depends on fbnd_pkg
`timescale 1ns / 1ps

module fbnd_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fbnd_pkg::PROD_W-1:0] dividend,
    input  logic [fbnd_pkg::DIM_W-1:0]  divisor,
    output logic                       done,
    output logic [fbnd_pkg::PROD_W-1:0] quot,
    output logic [fbnd_pkg::DIM_W-1:0]  rem
);
    import fbnd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  den_reg, den_next;
    logic [DIM_W:0]    shifted;
    logic [DIM_W:0]    trial;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], fits};
            rem_next = fits ? trial[DIM_W-1:0] : shifted[DIM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

/* sv/fbnd_ctrl.sv */
// fbnd_ctrl: sequencer for frame setup and pixel stepping
// depends on fbnd_pkg
`timescale 1ns / 1ps

module fbnd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tuser,
    output logic            s_tready,
    input  fbnd_pkg::stat_t stat,
    output fbnd_pkg::cmd_t  cmd
);
    import fbnd_pkg::*;

    typedef enum logic [10:0] {
        ST_RUN       = 11'b000_0000_0001,
        ST_CHECK     = 11'b000_0000_0010,
        ST_PROD_BHW  = 11'b000_0000_0100,
        ST_PICK      = 11'b000_0000_1000,
        ST_SIZE_GO   = 11'b000_0001_0000,
        ST_SIZE_WAIT = 11'b000_0010_0000,
        ST_COL_GO    = 11'b000_0100_0000,
        ST_COL_WAIT  = 11'b000_1000_0000,
        ST_ROW_GO    = 11'b001_0000_0000,
        ST_ROW_WAIT  = 11'b010_0000_0000,
        ST_PROC      = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_RUN) && stat.out_free;

    always_comb
    begin
        state_next    = state_reg;
        cmd.hold      = 1'b0;
        cmd.step_in   = 1'b0;
        cmd.step_held = 1'b0;
        cmd.op        = OP_NONE;
        case (state_reg)
            ST_RUN:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (s_tuser)
                    begin
                        cmd.hold   = 1'b1;
                        cmd.op     = OP_PROD_WH;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cmd.step_in = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.op     = OP_CHECK;
                state_next = stat.invalid ? ST_PROC : ST_PROD_BHW;
            end
            ST_PROD_BHW:
            begin
                cmd.op     = OP_PROD_BHW;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.op     = OP_PICK;
                state_next = stat.full_fit ? ST_COL_GO : ST_SIZE_GO;
            end
            ST_SIZE_GO:
            begin
                cmd.op     = OP_SIZE_GO;
                state_next = ST_SIZE_WAIT;
            end
            ST_SIZE_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_SIZE_DONE;
                    state_next = ST_COL_GO;
                end
            end
            ST_COL_GO:
            begin
                cmd.op     = OP_COL_GO;
                state_next = ST_COL_WAIT;
            end
            ST_COL_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_COL_DONE;
                    state_next = ST_ROW_GO;
                end
            end
            ST_ROW_GO:
            begin
                cmd.op     = OP_ROW_GO;
                state_next = ST_ROW_WAIT;
            end
            ST_ROW_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_ROW_DONE;
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                if (stat.out_free)
                begin
                    cmd.step_held = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/fbnd_datapath.sv */
// fbnd_datapath: config registers, setup arithmetic, sampling counters
// and output register; depends on fbnd_pkg and fbnd_div
`timescale 1ns / 1ps

module fbnd_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fbnd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbnd_pkg::DIM_W-1:0]     cfg_data,
    input  logic [fbnd_pkg::PIX_W-1:0]     s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fbnd_pkg::PIX_W-1:0]     m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser,
    input  fbnd_pkg::cmd_t                 cmd,
    output fbnd_pkg::stat_t                stat
);
    import fbnd_pkg::*;

    logic [DIM_W-1:0] src_width_reg, src_height_reg, box_width_reg, box_height_reg;

    logic              frame_ok_reg, frame_ok_next;
    logic [DIM_W-1:0]  out_w_reg, out_w_next, out_h_reg, out_h_next;
    logic [DIM_W-1:0]  col_quot_reg, col_quot_next, col_rem_reg, col_rem_next;
    logic [DIM_W-1:0]  row_quot_reg, row_quot_next, row_rem_reg, row_rem_next;
    logic [DIM_W-1:0]  src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [DIM_W-1:0]  out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic [DIM_W-1:0]  want_col_reg, want_col_next, col_acc_reg, col_acc_next;
    logic [DIM_W-1:0]  want_row_reg, want_row_next, row_acc_reg, row_acc_next;
    logic              wb_reg, wb_next;
    logic [PROD_W-1:0] prod_reg, prod_next, p1_reg, p1_next;
    logic [PIX_W-1:0]  hold_reg;
    logic              mvalid_reg, mvalid_next;
    logic [PIX_W-1:0]  mdata_reg, mdata_next;
    logic              mlast_reg, mlast_next, muser_reg, muser_next;

    logic [DIM_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              div_start, div_done;
    logic [PROD_W-1:0] div_dividend, div_quot;
    logic [DIM_W-1:0]  div_divisor, div_rem, size_q;

    logic             step, active, hit, re, fe, src_wrap;
    logic [PIX_W-1:0] pix;
    logic [DIM_W:0]   col_sum, row_sum;
    logic             col_carry, row_carry;
    logic [DIM_W-1:0] col_acc_new, col_pos_new, row_acc_new, row_pos_new;
    logic             full_fit, width_bound;

    fbnd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_W'(1);
            src_height_reg <= DIM_W'(1);
            box_width_reg  <= DIM_W'(1);
            box_height_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                CFG_BOX_WIDTH:  box_width_reg  <= cfg_data;
                CFG_BOX_HEIGHT: box_height_reg <= cfg_data;
                default:        src_width_reg  <= src_width_reg;
            endcase
        end
    end

    // setup arithmetic
    always_comb
    begin
        case (cmd.op)
            OP_PROD_WH:
            begin
                mul_a = src_width_reg;
                mul_b = src_height_reg;
            end
            OP_CHECK:
            begin
                mul_a = box_width_reg;
                mul_b = src_height_reg;
            end
            default:
            begin
                mul_a = box_height_reg;
                mul_b = src_width_reg;
            end
        endcase
    end

    assign mul_p = {{DIM_W{1'b0}}, mul_a} * {{DIM_W{1'b0}}, mul_b};

    assign stat.invalid = (src_width_reg == '0) || (src_height_reg == '0)
                       || (src_width_reg > DIM_W'(MAX_DIM))
                       || (src_height_reg > DIM_W'(MAX_DIM))
                       || (prod_reg > PROD_W'(PIXEL_LIMIT))
                       || (box_width_reg == '0) || (box_height_reg == '0);
    assign full_fit      = (box_width_reg >= src_width_reg)
                        && (box_height_reg >= src_height_reg);
    assign stat.full_fit = full_fit;
    assign width_bound   = p1_reg <= prod_reg;
    assign stat.div_done = div_done;

    assign div_start = (cmd.op inside {OP_SIZE_GO, OP_COL_GO, OP_ROW_GO});

    always_comb
    begin
        case (cmd.op)
            OP_SIZE_GO:
            begin
                div_dividend = wb_reg ? p1_reg : prod_reg;
                div_divisor  = wb_reg ? src_width_reg : src_height_reg;
            end
            OP_COL_GO:
            begin
                div_dividend = {{DIM_W{1'b0}}, src_width_reg};
                div_divisor  = out_w_reg;
            end
            default:
            begin
                div_dividend = {{DIM_W{1'b0}}, src_height_reg};
                div_divisor  = out_h_reg;
            end
        endcase
    end

    assign size_q = (div_quot[DIM_W-1:0] == '0) ? DIM_W'(1) : div_quot[DIM_W-1:0];

    // sampling step
    assign step     = cmd.step_in | cmd.step_held;
    assign pix      = cmd.step_held ? hold_reg : s_tdata;
    assign active   = frame_ok_reg && (out_row_reg < out_h_reg);
    assign hit      = active && (src_row_reg == want_row_reg)
                   && (src_col_reg == want_col_reg) && (out_col_reg < out_w_reg);
    assign re       = ({1'b0, out_col_reg} + 1'b1) == {1'b0, out_w_reg};
    assign fe       = re && (({1'b0, out_row_reg} + 1'b1) == {1'b0, out_h_reg});
    assign src_wrap = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, src_width_reg};

    assign col_sum     = {1'b0, col_acc_reg} + {1'b0, col_rem_reg};
    assign col_carry   = col_sum >= {1'b0, out_w_reg};
    assign col_acc_new = col_carry ? DIM_W'(col_sum - {1'b0, out_w_reg})
                                   : col_sum[DIM_W-1:0];
    assign col_pos_new = want_col_reg + col_quot_reg + DIM_W'(col_carry);
    assign row_sum     = {1'b0, row_acc_reg} + {1'b0, row_rem_reg};
    assign row_carry   = row_sum >= {1'b0, out_h_reg};
    assign row_acc_new = row_carry ? DIM_W'(row_sum - {1'b0, out_h_reg})
                                   : row_sum[DIM_W-1:0];
    assign row_pos_new = want_row_reg + row_quot_reg + DIM_W'(row_carry);

    assign stat.out_free = !mvalid_reg || m_tready;

    always_comb
    begin
        frame_ok_next = frame_ok_reg;
        out_w_next    = out_w_reg;
        out_h_next    = out_h_reg;
        col_quot_next = col_quot_reg;
        col_rem_next  = col_rem_reg;
        row_quot_next = row_quot_reg;
        row_rem_next  = row_rem_reg;
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        want_col_next = want_col_reg;
        col_acc_next  = col_acc_reg;
        want_row_next = want_row_reg;
        row_acc_next  = row_acc_reg;
        wb_next       = wb_reg;
        prod_next     = prod_reg;
        p1_next       = p1_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        mdata_next    = mdata_reg;
        mlast_next    = mlast_reg;
        muser_next    = muser_reg;

        if (cmd.op inside {OP_PROD_WH, OP_CHECK, OP_PROD_BHW})
        begin
            prod_next = mul_p;
        end

        case (cmd.op)
            OP_PROD_WH:
            begin
                frame_ok_next = 1'b0;
                out_w_next    = '0;
                out_h_next    = '0;
                col_quot_next = '0;
                col_rem_next  = '0;
                row_quot_next = '0;
                row_rem_next  = '0;
                src_col_next  = '0;
                src_row_next  = '0;
                out_col_next  = '0;
                out_row_next  = '0;
                want_col_next = '0;
                col_acc_next  = '0;
                want_row_next = '0;
                row_acc_next  = '0;
            end
            OP_PROD_BHW:
            begin
                p1_next = prod_reg;
            end
            OP_PICK:
            begin
                wb_next = width_bound;
                if (full_fit)
                begin
                    out_w_next = src_width_reg;
                    out_h_next = src_height_reg;
                end
                else if (width_bound)
                begin
                    out_w_next = box_width_reg;
                end
                else
                begin
                    out_h_next = box_height_reg;
                end
            end
            OP_SIZE_DONE:
            begin
                if (wb_reg)
                begin
                    out_h_next = size_q;
                end
                else
                begin
                    out_w_next = size_q;
                end
            end
            OP_COL_DONE:
            begin
                col_quot_next = div_quot[DIM_W-1:0];
                col_rem_next  = div_rem;
            end
            OP_ROW_DONE:
            begin
                row_quot_next = div_quot[DIM_W-1:0];
                row_rem_next  = div_rem;
                frame_ok_next = 1'b1;
            end
            default:
            begin
                wb_next = wb_reg;
            end
        endcase

        if (step && active)
        begin
            if (hit)
            begin
                mvalid_next = 1'b1;
                mdata_next  = pix | OPAQUE;
                mlast_next  = re;
                muser_next  = fe;
                if (re)
                begin
                    out_col_next  = '0;
                    want_col_next = '0;
                    col_acc_next  = '0;
                    out_row_next  = out_row_reg + 1'b1;
                    want_row_next = row_pos_new;
                    row_acc_next  = row_acc_new;
                end
                else
                begin
                    out_col_next  = out_col_reg + 1'b1;
                    want_col_next = col_pos_new;
                    col_acc_next  = col_acc_new;
                end
            end
            if (src_wrap)
            begin
                src_col_next = '0;
                src_row_next = src_row_reg + 1'b1;
            end
            else
            begin
                src_col_next = src_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ok_reg <= 1'b0;
            out_w_reg    <= '0;
            out_h_reg    <= '0;
            col_quot_reg <= '0;
            col_rem_reg  <= '0;
            row_quot_reg <= '0;
            row_rem_reg  <= '0;
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            want_col_reg <= '0;
            col_acc_reg  <= '0;
            want_row_reg <= '0;
            row_acc_reg  <= '0;
            wb_reg       <= 1'b0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            frame_ok_reg <= frame_ok_next;
            out_w_reg    <= out_w_next;
            out_h_reg    <= out_h_next;
            col_quot_reg <= col_quot_next;
            col_rem_reg  <= col_rem_next;
            row_quot_reg <= row_quot_next;
            row_rem_reg  <= row_rem_next;
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            want_col_reg <= want_col_next;
            col_acc_reg  <= col_acc_next;
            want_row_reg <= want_row_next;
            row_acc_reg  <= row_acc_next;
            wb_reg       <= wb_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        p1_reg    <= p1_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
        if (cmd.hold)
        begin
            hold_reg <= s_tdata;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

endmodule

/* sv/fit_box_nearest_downscaler.sv */
// fit_box_nearest_downscaler: top level, joins controller and datapath
// depends on fbnd_pkg, fbnd_ctrl, fbnd_datapath
//
//   port group  dir  payload
//   s_*         in   tdata: src_pixel[31:0]; tuser: frame_start
//   m_*         out  tdata: out_pixel[31:0]; tlast: row_end; tuser: frame_end
//   cfg_*       in   index 0..3 = src_width, src_height, box_width, box_height
//
// a frame-start word holds off input while setup runs the one-bit-per-cycle
// divider up to three times; a plain pixel needs no setup
// reset clears all counters; config registers reset to 1; no clearing pass
// input is held off while the output register is full and not taken
`timescale 1ns / 1ps

module fit_box_nearest_downscaler
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fbnd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbnd_pkg::DIM_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fbnd_pkg::PIX_W-1:0]     s_tdata,  // src_pixel
    input  logic                           s_tuser,  // frame_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fbnd_pkg::PIX_W-1:0]     m_tdata,  // out_pixel
    output logic                           m_tlast,
    output logic                           m_tuser   // frame_end
);
    import fbnd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fbnd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbnd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* test/fit_box_nearest_downscaler_test.sv */
// fit_box_nearest_downscaler_test: self-checking bench for the fit-box nearest downscaler
// streams bgra frames through the block, predicts the picked pixels, compares each out word
// depends on fbnd_pkg and fit_box_nearest_downscaler
`timescale 1ns / 1ps

module fit_box_nearest_downscaler_test;

    import fbnd_pkg::*;

    localparam int SETTLE   = 200;
    localparam int WATCHDOG = 4000;
    localparam int ITEMS    = 920;

    typedef struct {
        bit [PIX_W-1:0] pixel;
        bit             row_end;
        bit             frame_end;
    } pick_t;

    class downscale_check;
        bit [DIM_W-1:0] regs [4] = '{1, 1, 1, 1};
        bit             frame_ok;
        bit [DIM_W-1:0] out_w, out_h, col_quot, col_rem, row_quot, row_rem;
        bit [DIM_W-1:0] src_col, src_row, out_col, out_row;
        bit [DIM_W-1:0] want_col, want_col_acc, want_row, want_row_acc;
        pick_t          picked_q [$];
        int             errors;
        int             useful;
        int             taken;

        function bit [2*DIM_W-1:0] advance(bit [DIM_W-1:0] pos, acc, quot, rem, den);
            int unsigned a, p;
            a = 32'(acc) + 32'(rem);
            p = 32'(pos) + 32'(quot);
            if (a >= 32'(den))
            begin
                a = a - 32'(den);
                p = p + 1;
            end
            return {p[DIM_W-1:0], a[DIM_W-1:0]};
        endfunction

        function void size_frame();
            longint unsigned w, h, bw, bh, ow, oh;
            w  = 64'(regs[CFG_SRC_WIDTH]);
            h  = 64'(regs[CFG_SRC_HEIGHT]);
            bw = 64'(regs[CFG_BOX_WIDTH]);
            bh = 64'(regs[CFG_BOX_HEIGHT]);
            frame_ok = 1'b0;
            {out_w, out_h, col_quot, col_rem, row_quot, row_rem} = '0;
            {src_col, src_row, out_col, out_row} = '0;
            {want_col, want_col_acc, want_row, want_row_acc} = '0;
            if (w == 0 || h == 0 || w > MAX_DIM || h > MAX_DIM || w * h > PIXEL_LIMIT)
                return;
            if (bw == 0 || bh == 0)
                return;
            if (bw >= w && bh >= h)
            begin
                ow = w;
                oh = h;
            end
            else if (bw * h <= bh * w)
            begin
                ow = bw;
                oh = (h * bw) / w;
            end
            else
            begin
                oh = bh;
                ow = (w * bh) / h;
            end
            if (ow < 1)
                ow = 1;
            if (oh < 1)
                oh = 1;
            out_w    = DIM_W'(ow);
            out_h    = DIM_W'(oh);
            col_quot = DIM_W'(w / ow);
            col_rem  = DIM_W'(w % ow);
            row_quot = DIM_W'(h / oh);
            row_rem  = DIM_W'(h % oh);
            frame_ok = 1'b1;
        endfunction

        function void take_source(bit [PIX_W-1:0] pix, bit start);
            bit    re, fe;
            pick_t next_pick;
            taken++;
            if (start)
                size_frame();
            if (!frame_ok || out_row >= out_h)
                return;
            useful++;
            if (src_row == want_row && src_col == want_col && out_col < out_w)
            begin
                re = (out_col + 1 == out_w);
                fe = re && (out_row + 1 == out_h);
                next_pick = '{pix | OPAQUE, re, fe};
                picked_q.insert(picked_q.size(), next_pick);
                if (re)
                begin
                    out_col      = '0;
                    want_col     = '0;
                    want_col_acc = '0;
                    out_row      = out_row + 1'b1;
                    {want_row, want_row_acc} = advance(want_row, want_row_acc,
                                                       row_quot, row_rem, out_h);
                end
                else
                begin
                    out_col = out_col + 1'b1;
                    {want_col, want_col_acc} = advance(want_col, want_col_acc,
                                                       col_quot, col_rem, out_w);
                end
            end
            // column wrap follows the live width register
            if (src_col + 1 >= regs[CFG_SRC_WIDTH])
            begin
                src_col = '0;
                src_row = src_row + 1'b1;
            end
            else
                src_col = src_col + 1'b1;
        endfunction

        function void match_output(logic [PIX_W-1:0] pix, logic re, logic fe);
            pick_t exp_word;
            if (picked_q.size() == 0)
            begin
                $error("out word %h with no pixel pending", pix);
                errors++;
                return;
            end
            exp_word = picked_q.pop_front();
            if (pix !== exp_word.pixel)
            begin
                $error("out_pixel: expected %h, actual %h", exp_word.pixel, pix);
                errors++;
            end
            if (re !== exp_word.row_end)
            begin
                $error("row_end: expected %b, actual %b", exp_word.row_end, re);
                errors++;
            end
            if (fe !== exp_word.frame_end)
            begin
                $error("frame_end: expected %b, actual %b", exp_word.frame_end, fe);
                errors++;
            end
        endfunction

        function int pending();
            return picked_q.size();
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    downscale_check board = new;
    int             burst_left;
    int             quiet;
    int             stall_mode;
    int             stall_left;
    int unsigned    rx_tick;

    fit_box_nearest_downscaler DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    // receiver ready follows one of four stall modes, picked again at random
    always @(posedge clk)
    begin
        rx_tick++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= (rx_tick % 5 < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.match_output(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready)
                board.take_source(s_tdata, s_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_word(input bit [PIX_W-1:0] pix, input bit start);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input bit [DIM_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.regs[idx] = val;
    endtask

    function automatic bit [DIM_W-1:0] src_dim();
        case ($urandom_range(0, 19))
            0:       return DIM_W'($urandom_range(0, 32767));
            1:       return DIM_W'($urandom_range(13, 40));
            default: return DIM_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic bit [DIM_W-1:0] box_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_W'(MAX_DIM);
            2:       return DIM_W'($urandom_range(0, 32767));
            default: return DIM_W'($urandom_range(1, 12));
        endcase
    endfunction

    initial
    begin
        longint unsigned frame_len;
        int              n;
        int              pause_at;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // stray word before any frame, 1x1 frame, then a trailing extra word
        send_word($urandom, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hffff_ffff, 1'b0);

        // oversized box keeps full size; first frame is cut short by a new start
        wait_idle(SETTLE);
        write_reg(CFG_SRC_WIDTH, 3);
        write_reg(CFG_SRC_HEIGHT, 2);
        write_reg(CFG_BOX_WIDTH, MAX_DIM);
        write_reg(CFG_BOX_HEIGHT, MAX_DIM);
        send_word($urandom, 1'b1);
        send_word($urandom, 1'b0);
        send_word(32'hffff_ffff, 1'b1);
        for (int i = 0; i < 5; i++)
            send_word($urandom, 1'b0);

        // zero box dimensions
        wait_idle(SETTLE);
        write_reg(CFG_BOX_WIDTH, 0);
        send_word($urandom, 1'b1);
        send_word($urandom, 1'b0);
        wait_idle(SETTLE);
        write_reg(CFG_BOX_WIDTH, 5);
        write_reg(CFG_BOX_HEIGHT, 0);
        send_word($urandom, 1'b1);
        send_word($urandom, 1'b0);

        // pixel count just over and at the frame limit
        wait_idle(SETTLE);
        write_reg(CFG_SRC_WIDTH, MAX_DIM);
        write_reg(CFG_SRC_HEIGHT, 4097);
        write_reg(CFG_BOX_WIDTH, 1);
        write_reg(CFG_BOX_HEIGHT, 1);
        send_word($urandom, 1'b1);
        wait_idle(SETTLE);
        write_reg(CFG_SRC_HEIGHT, 4096);
        send_word($urandom, 1'b1);
        send_word($urandom, 1'b0);

        // width over the largest dimension
        wait_idle(SETTLE);
        write_reg(CFG_SRC_WIDTH, 15'h7fff);
        send_word($urandom, 1'b1);

        while (board.taken < ITEMS)
        begin
            if (board.useful < 30 || $urandom_range(0, 9) < 4)
            begin
                wait_idle(SETTLE);
                if (board.useful < 30 || $urandom_range(0, 3) != 0)
                    write_reg(CFG_SRC_WIDTH, src_dim());
                if (board.useful < 30 || $urandom_range(0, 3) != 0)
                    write_reg(CFG_SRC_HEIGHT, src_dim());
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_BOX_WIDTH, box_dim());
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_BOX_HEIGHT, box_dim());
            end
            if ($urandom_range(0, 14) == 0)
                repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
            frame_len = 64'(board.regs[CFG_SRC_WIDTH]) * 64'(board.regs[CFG_SRC_HEIGHT]);
            if (frame_len == 0 || frame_len > 300)
                n = $urandom_range(1, 30);
            else
                case ($urandom_range(0, 9))
                    0:       n = $urandom_range(1, 32'(frame_len));
                    1:       n = int'(frame_len) + $urandom_range(1, 6);
                    default: n = int'(frame_len);
                endcase
            pause_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    wait_idle(0);
                send_word($urandom, i == 0);
            end
        end

        wait_idle(SETTLE);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
